>>> hw/rtl/wip_pkg.sv
// Shared types, constants and the reset wave table of the wave table interpolating player.
// Used by wip_ctrl, wip_datapath and wavetable_interp_player; depends on nothing else.
package wip_pkg;

    // Table geometry and interpolation depth. SUBSTEPS must be a power of two.
    localparam int TBL_LEN   = 32;
    localparam int TBL_AW    = $clog2(TBL_LEN);
    localparam int SI_W      = $clog2(TBL_LEN + 1);
    localparam int SUBSTEPS  = 4;
    localparam int SUB_SHIFT = $clog2(SUBSTEPS);

    // Field widths.
    localparam int DUR_W  = 16;
    localparam int AMP_W  = 8;
    localparam int SMP_W  = 8;
    localparam int TIME_W = 32;
    localparam int IDX_W  = 5;
    localparam int SC_W   = 8;
    localparam int AMP_FRAC = 7;

    // Step length is duration / (TBL_LEN - 1), done as a reciprocal multiply.
    localparam int LEN_MAX     = (2 ** DUR_W - 1) / (TBL_LEN - 1);
    localparam int LEN_W       = $clog2(LEN_MAX + 1);
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP       = (2 ** RECIP_SHIFT) / (TBL_LEN - 1);
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int DIVP_W      = DUR_W + RECIP_W;

    // Derived datapath widths.
    localparam int SLOPE_W   = SMP_W + 1;
    localparam int SLOPE_MAX = (2 ** SMP_W - 1) / SUBSTEPS;
    localparam int BOUND_W   = SI_W + LEN_W;
    localparam int SCL_W     = SC_W + LEN_W;
    localparam int SUBB_W    = BOUND_W + 1;
    localparam int SPROD_W   = SC_W + SLOPE_W + 1;
    localparam int LVL_W     = SPROD_W + 1;
    localparam int SCP_W     = SMP_W + AMP_W;

    // Item opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes (address bit 2 of the APB port).
    localparam logic REG_DURATION  = 1'b0;
    localparam logic REG_AMPLITUDE = 1'b1;
    localparam int   PADDR_W       = 3;
    localparam int   PDATA_W       = 32;

    // Table read address selection.
    typedef logic [2:0] wip_rdsel_t;
    localparam wip_rdsel_t RA_ZERO  = 3'd0;
    localparam wip_rdsel_t RA_ONE   = 3'd1;
    localparam wip_rdsel_t RA_SI    = 3'd2;
    localparam wip_rdsel_t RA_SI_M1 = 3'd3;
    localparam wip_rdsel_t RA_SI_P1 = 3'd4;

    typedef struct packed {
        logic       accept;
        wip_rdsel_t rd_sel;
        logic       cap_cur;
        logic       cap_prev;
        logic       eval_mul;
        logic       eval_sum;
        logic       start_cycle;
        logic       stop_cycle;
        logic       point_adv;
        logic       point_slope;
        logic       sub_mul;
        logic       sub_adv;
        logic       scale;
        logic       emit;
    } wip_cmd_t;

    typedef struct packed {
        logic cycling;
        logic end_hit;
        logic pt_hit;
        logic sub_hit;
        logic out_free;
    } wip_stat_t;

    localparam logic [SMP_W-1:0] SINE_POINTS [32] = '{
        8'd127, 8'd233, 8'd242, 8'd144, 8'd30,  8'd5,   8'd91,  8'd210,
        8'd252, 8'd179, 8'd57,  8'd0,   8'd58,  8'd180, 8'd252, 8'd209,
        8'd90,  8'd4,   8'd31,  8'd146, 8'd242, 8'd233, 8'd125, 8'd19,
        8'd11,  8'd110, 8'd223, 8'd248, 8'd161, 8'd42,  8'd1,   8'd75
    };

    // Reset contents of a table entry: the built-in sine, repeated every 32 entries.
    function automatic logic [SMP_W-1:0] sine_point(input logic [TBL_AW-1:0] addr);
        logic [8:0] wide;
        wide = 9'(addr);
        return SINE_POINTS[wide[4:0]];
    endfunction

endpackage

>>> hw/rtl/wip_ctrl.sv
// Sequencing state machine of the wave table interpolating player.
// Depends on wip_pkg; drives the command word of wip_datapath from its status word.
module wip_ctrl
    import wip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      op,
    output logic      in_ready,
    input  wip_stat_t stat,
    output wip_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START0 = 4'd1;
    localparam logic [3:0] ST_START1 = 4'd2;
    localparam logic [3:0] ST_START2 = 4'd3;
    localparam logic [3:0] ST_EVAL0  = 4'd4;
    localparam logic [3:0] ST_EVAL1  = 4'd5;
    localparam logic [3:0] ST_DECIDE = 4'd6;
    localparam logic [3:0] ST_POINT0 = 4'd7;
    localparam logic [3:0] ST_POINT1 = 4'd8;
    localparam logic [3:0] ST_SUB0   = 4'd9;
    localparam logic [3:0] ST_SUB1   = 4'd10;
    localparam logic [3:0] ST_SCALE  = 4'd11;
    localparam logic [3:0] ST_EMIT   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RA_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && op == OP_TICK)
                begin
                    state_next = stat.cycling ? ST_EVAL0 : ST_START0;
                end
            end
            ST_START0:
            begin
                cmd.rd_sel = RA_ZERO;
                state_next = ST_START1;
            end
            ST_START1:
            begin
                cmd.rd_sel  = RA_ONE;
                cmd.cap_cur = 1'b1;
                state_next  = ST_START2;
            end
            ST_START2:
            begin
                cmd.start_cycle = 1'b1;
                state_next      = ST_SCALE;
            end
            ST_EVAL0:
            begin
                cmd.rd_sel   = RA_SI;
                cmd.eval_mul = 1'b1;
                state_next   = ST_EVAL1;
            end
            ST_EVAL1:
            begin
                cmd.rd_sel   = RA_SI_M1;
                cmd.cap_cur  = 1'b1;
                cmd.eval_sum = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.cap_prev = 1'b1;
                if (stat.end_hit)
                begin
                    cmd.stop_cycle = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (stat.pt_hit)
                begin
                    state_next = ST_POINT0;
                end
                else if (stat.sub_hit)
                begin
                    state_next = ST_SUB0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POINT0:
            begin
                cmd.rd_sel    = RA_SI_P1;
                cmd.point_adv = 1'b1;
                state_next    = ST_POINT1;
            end
            ST_POINT1:
            begin
                cmd.point_slope = 1'b1;
                state_next      = ST_SCALE;
            end
            ST_SUB0:
            begin
                cmd.sub_mul = 1'b1;
                state_next  = ST_SUB1;
            end
            ST_SUB1:
            begin
                cmd.sub_adv = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A new word is only placed in the output register once the old one has gone.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("output word loaded over a pending one");

    // Ending a cycle really drops the datapath out of the cycling state.
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && stat.end_hit) |=> !stat.cycling)
        else $error("cycle end did not clear cycling");

    // Starting a cycle sets cycling and heads for the scaler.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_cycle |=> (stat.cycling && state_reg == ST_SCALE))
        else $error("cycle start did not take effect");

endmodule

>>> hw/rtl/wip_datapath.sv
// Datapath of the wave table interpolating player: table memory, timing bounds,
// slope, interpolation, gain and the output register. Depends on wip_pkg.
module wip_datapath
    import wip_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  wip_cmd_t          cmd,
    output wip_stat_t         stat,
    input  logic              op,
    input  logic [TIME_W-1:0] time_ms,
    input  logic [IDX_W-1:0]  table_index,
    input  logic [SMP_W-1:0]  table_value,
    input  logic [DUR_W-1:0]  cycle_duration_ms,
    input  logic [AMP_W-1:0]  amplitude_q1_7,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SMP_W-1:0]  drive_level
);

    // Table memory; entries not yet loaded read as the built-in sine.
    logic [SMP_W-1:0]   mem [TBL_LEN];
    logic [TBL_LEN-1:0] wvld_reg;
    logic               mem_we;
    logic [TBL_AW-1:0]  mem_wa;
    logic [TBL_AW-1:0]  rd_addr;
    logic [SMP_W-1:0]   rd_raw_reg;
    logic [SMP_W-1:0]   rd_def_reg;
    logic               rd_hit_reg;
    logic [SMP_W-1:0]   rd_data;

    // Cycle state.
    logic                      cycling_reg, cycling_next;
    logic [TIME_W-1:0]         phase_reg, phase_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [SI_W-1:0]           si_reg, si_next;
    logic [SC_W-1:0]           sc_reg, sc_next;
    logic signed [SLOPE_W-1:0] slope_reg, slope_next;

    // Working registers.
    logic [TIME_W-1:0]         time_reg;
    logic [DIVP_W-1:0]         div_prod_reg;
    logic [LEN_W-1:0]          q_est_reg;
    logic [TIME_W-1:0]         elapsed_reg;
    logic [BOUND_W-1:0]        pt_bound_reg;
    logic [BOUND_W-1:0]        sub_a_reg;
    logic [SCL_W-1:0]          sc_len_reg;
    logic [SUBB_W-1:0]         sub_bound_reg;
    logic [SMP_W-1:0]          cur_reg;
    logic [SMP_W-1:0]          prev_reg;
    logic [SMP_W-1:0]          level_reg;
    logic signed [SPROD_W-1:0] sub_prod_reg;
    logic [SCP_W-1:0]          scale_prod_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [SMP_W-1:0]          drive_level_reg;

    // Combinational helpers.
    logic [DUR_W-1:0]          q_mul;
    logic [DUR_W-1:0]          q_rem;
    logic [LEN_W-1:0]          len_fix;
    logic signed [SLOPE_W-1:0] pair_diff;
    logic [SLOPE_W-1:0]        pair_bias;
    logic signed [SLOPE_W-1:0] pair_adj;
    logic signed [SLOPE_W-1:0] pair_slope;
    logic [SI_W-1:0]           si_m1;
    logic signed [SPROD_W-1:0] sc_s;
    logic signed [SPROD_W-1:0] slope_s;
    logic signed [LVL_W-1:0]   lvl_sum;
    logic [SMP_W-1:0]          lvl_clamp;
    logic [SMP_W:0]            scaled;
    logic [SMP_W-1:0]          scaled_sat;

    assign mem_we = cmd.accept && (op == OP_LOAD) && (int'(table_index) < TBL_LEN);
    assign mem_wa = TBL_AW'(table_index);
    assign si_m1  = si_reg - SI_W'(1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RA_ZERO:  rd_addr = '0;
            RA_ONE:   rd_addr = TBL_AW'(1);
            RA_SI:    rd_addr = si_reg[TBL_AW-1:0];
            RA_SI_M1: rd_addr = si_m1[TBL_AW-1:0];
            RA_SI_P1: rd_addr = TBL_AW'(si_reg + SI_W'(1));
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= table_value;
        end
        rd_raw_reg <= mem[rd_addr];
        rd_def_reg <= sine_point(rd_addr);
        rd_hit_reg <= wvld_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvld_reg <= '0;
        end
        else if (mem_we)
        begin
            wvld_reg[mem_wa] <= 1'b1;
        end
    end

    assign rd_data = rd_hit_reg ? rd_raw_reg : rd_def_reg;

    // The reciprocal estimate is at most one short; one compare puts it right.
    assign q_mul   = DUR_W'(q_est_reg) * DUR_W'(TBL_LEN - 1);
    assign q_rem   = cycle_duration_ms - q_mul;
    assign len_fix = (q_rem >= DUR_W'(TBL_LEN - 1)) ? q_est_reg + LEN_W'(1) : q_est_reg;

    // Slope between the entry just read and the one held in cur_reg, rounded toward zero.
    always_comb
    begin
        pair_diff  = $signed({1'b0, rd_data}) - $signed({1'b0, cur_reg});
        pair_bias  = pair_diff[SLOPE_W-1] ? SLOPE_W'(SUBSTEPS - 1) : '0;
        pair_adj   = pair_diff + $signed(pair_bias);
        pair_slope = pair_adj >>> SUB_SHIFT;
    end

    // Interpolated level, clamped to the sample range.
    always_comb
    begin
        sc_s    = SPROD_W'(sc_reg);
        slope_s = SPROD_W'(slope_reg);
        lvl_sum = LVL_W'(sub_prod_reg) + LVL_W'($signed({1'b0, prev_reg}));
        if (lvl_sum < 0)
        begin
            lvl_clamp = '0;
        end
        else if (lvl_sum > LVL_W'(2 ** SMP_W - 1))
        begin
            lvl_clamp = '1;
        end
        else
        begin
            lvl_clamp = lvl_sum[SMP_W-1:0];
        end
    end

    assign scaled     = scale_prod_reg[SCP_W-1:AMP_FRAC];
    assign scaled_sat = scaled[SMP_W] ? '1 : scaled[SMP_W-1:0];

    always_comb
    begin
        cycling_next = cycling_reg;
        phase_next   = phase_reg;
        len_next     = len_reg;
        si_next      = si_reg;
        sc_next      = sc_reg;
        slope_next   = slope_reg;
        if (cmd.start_cycle)
        begin
            cycling_next = 1'b1;
            phase_next   = time_reg;
            len_next     = len_fix;
            si_next      = SI_W'(1);
            sc_next      = '0;
            slope_next   = pair_slope;
        end
        if (cmd.stop_cycle)
        begin
            cycling_next = 1'b0;
        end
        if (cmd.point_adv)
        begin
            si_next = si_reg + SI_W'(1);
            sc_next = SC_W'(1);
        end
        if (cmd.point_slope)
        begin
            slope_next = (si_reg >= SI_W'(TBL_LEN)) ? '0 : pair_slope;
        end
        if (cmd.sub_adv)
        begin
            sc_next = sc_reg + SC_W'(1);
        end
    end

    assign out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycling_reg   <= 1'b0;
            phase_reg     <= '0;
            len_reg       <= '0;
            si_reg        <= '0;
            sc_reg        <= '0;
            slope_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cycling_reg   <= cycling_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            si_reg        <= si_next;
            sc_reg        <= sc_next;
            slope_reg     <= slope_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_prod_reg <= DIVP_W'(cycle_duration_ms) * DIVP_W'(RECIP);
        q_est_reg    <= LEN_W'(div_prod_reg >> RECIP_SHIFT);
        if (cmd.accept)
        begin
            time_reg <= time_ms;
        end
        if (cmd.eval_mul)
        begin
            elapsed_reg  <= time_reg - phase_reg;
            pt_bound_reg <= BOUND_W'(si_reg) * BOUND_W'(len_reg);
            sub_a_reg    <= BOUND_W'(si_m1) * BOUND_W'(len_reg);
            sc_len_reg   <= SCL_W'(sc_reg) * SCL_W'(len_reg);
        end
        if (cmd.eval_sum)
        begin
            sub_bound_reg <= SUBB_W'(sub_a_reg) + SUBB_W'(sc_len_reg >> SUB_SHIFT);
        end
        if (cmd.cap_cur)
        begin
            cur_reg <= rd_data;
        end
        if (cmd.cap_prev)
        begin
            prev_reg <= rd_data;
        end
        if (cmd.start_cycle || cmd.point_adv)
        begin
            level_reg <= cur_reg;
        end
        else if (cmd.sub_adv)
        begin
            level_reg <= lvl_clamp;
        end
        if (cmd.sub_mul)
        begin
            sub_prod_reg <= sc_s * slope_s;
        end
        if (cmd.scale)
        begin
            scale_prod_reg <= SCP_W'(level_reg) * SCP_W'(amplitude_q1_7);
        end
        if (cmd.emit)
        begin
            drive_level_reg <= scaled_sat;
        end
    end

    assign stat.cycling  = cycling_reg;
    assign stat.end_hit  = (si_reg >= SI_W'(TBL_LEN))
                           || (elapsed_reg >= TIME_W'(cycle_duration_ms));
    assign stat.pt_hit   = elapsed_reg > TIME_W'(pt_bound_reg);
    assign stat.sub_hit  = elapsed_reg > TIME_W'(sub_bound_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign drive_level = drive_level_reg;

    // While a cycle runs, the next point index stays within one past the table end.
    a_si_range: assert property (@(posedge clk) disable iff (!rst_n)
        cycling_reg |-> (si_reg != '0 && si_reg <= SI_W'(TBL_LEN)))
        else $error("step index out of range while cycling");

    // A fresh cycle always begins at point one with no sub-steps taken.
    a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cycling_reg) |-> (si_reg == SI_W'(1) && sc_reg == '0))
        else $error("cycle started from stale indexes");

    // The slope is a sample difference divided down, so it is bounded.
    a_slope: assert property (@(posedge clk) disable iff (!rst_n)
        (slope_reg >= -SLOPE_MAX && slope_reg <= SLOPE_MAX))
        else $error("slope out of range");

endmodule

>>> hw/rtl/wavetable_interp_player.sv
// Top level of the wave table interpolating player: APB configuration registers
// and the joining of wip_ctrl and wip_datapath. Depends on wip_pkg.
//
// The block plays one cycle of a 32-entry, 8-bit wave table over cycle_duration_ms
// milliseconds. Each input word is either a time tick (op 0, carrying time_ms) or a
// table load (op 1, writing table_value at table_index). A tick while idle starts a
// cycle and gives table entry 0; a tick during a cycle gives the next table point
// once its time boundary has passed, an interpolated level once a quarter-step
// boundary has passed, ends the cycle when the table or the duration is used up, or
// gives nothing. Every level is scaled by the Q1.7 gain amplitude_q1_7 and held at
// 255 at most; a tick gives at most one output word and a load gives none. The
// table comes out of reset holding a sine; loads take effect immediately, also
// within a running cycle, and no clearing pass is needed after reset. Items are
// taken one at a time: a load ends on acceptance, while a tick holds the input side
// until its level is loaded into the output register or, when it gives no word, until
// the decide state. The length of a tick is set by the single read port of
// the table memory, which the controller visits two or three times per
// tick, and by the registered multiplies for the step bounds, the
// interpolation and the gain. The output register frees the input side:
// a result waits there while the next word is accepted, and only an output word that
// is still untaken when the following result is ready holds the sequencer back.
// Registers sit at byte address 0 (cycle_duration_ms, reset 1000) and 4
// (amplitude_q1_7, reset 128) and should be written only while the block is idle.
module wavetable_interp_player
    import wip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [TIME_W-1:0]  time_ms,
    input  logic [IDX_W-1:0]   table_index,
    input  logic [SMP_W-1:0]   table_value,
    // Output words
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SMP_W-1:0]   drive_level
);

    logic [DUR_W-1:0] cycle_duration_ms_reg, cycle_duration_ms_next;
    logic [AMP_W-1:0] amplitude_q1_7_reg, amplitude_q1_7_next;
    logic             cfg_wr;
    wip_cmd_t         cmd;
    wip_stat_t        stat;

    // The port never waits, so a write lands at the edge that ends its access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cycle_duration_ms_next = cycle_duration_ms_reg;
        amplitude_q1_7_next    = amplitude_q1_7_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_DURATION:  cycle_duration_ms_next = pwdata[DUR_W-1:0];
                REG_AMPLITUDE: amplitude_q1_7_next    = pwdata[AMP_W-1:0];
                default:       cycle_duration_ms_next = cycle_duration_ms_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DURATION:  prdata = PDATA_W'(cycle_duration_ms_reg);
            REG_AMPLITUDE: prdata = PDATA_W'(amplitude_q1_7_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_duration_ms_reg <= DUR_W'(1000);
            amplitude_q1_7_reg    <= AMP_W'(128);
        end
        else
        begin
            cycle_duration_ms_reg <= cycle_duration_ms_next;
            amplitude_q1_7_reg    <= amplitude_q1_7_next;
        end
    end

    // The controller sequences table reads and arithmetic steps for each word.
    wip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the table, the cycle state and the output register.
    wip_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .op                (op),
        .time_ms           (time_ms),
        .table_index       (table_index),
        .table_value       (table_value),
        .cycle_duration_ms (cycle_duration_ms_reg),
        .amplitude_q1_7    (amplitude_q1_7_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .drive_level       (drive_level)
    );

endmodule

>>> bench/wip_tb_pkg.sv
// Scoreboard class for the wave table interpolating player bench: a cycle-free
// predictor of drive_level words and the queue of levels still owed by the block.
// Depends on wip_pkg for widths, opcodes, register indexes and the reset sine table.
package wip_tb_pkg;
    import wip_pkg::*;

    class level_scoreboard;
        // Predictor copy of the block's registers and playback state.
        logic [SMP_W-1:0]         wave [TBL_LEN];
        logic [DUR_W-1:0]         duration;
        logic [AMP_W-1:0]         gain;
        logic                     cycling;
        logic [TIME_W-1:0]        phase_start;
        logic [LEN_W-1:0]         step_length;
        logic [SI_W-1:0]          step_index;
        logic signed [SLOPE_W-1:0] step_slope;
        logic [SC_W-1:0]          substep_count;

        logic [SMP_W-1:0] pending_levels [$];
        int unsigned      mismatches;

        function new();
            for (int i = 0; i < TBL_LEN; i++) begin
                wave[i] = SINE_POINTS[i % 32];
            end
            duration      = 1000;
            gain          = 128;
            cycling       = 1'b0;
            phase_start   = '0;
            step_length   = '0;
            step_index    = '0;
            step_slope    = '0;
            substep_count = '0;
            mismatches    = 0;
        endfunction

        // One line per failure, and every failure is counted.
        task report(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        function void set_register(logic sel, logic [PDATA_W-1:0] value);
            if (sel == REG_DURATION) begin
                duration = value[DUR_W-1:0];
            end else begin
                gain = value[AMP_W-1:0];
            end
        endfunction

        function int unsigned pending();
            return pending_levels.size();
        endfunction

        // Clamp to the sample range, apply the Q1.7 gain, truncate and saturate.
        function logic [SMP_W-1:0] scaled(int level);
            int prod;
            if (level < 0) begin
                level = 0;
            end else if (level > 255) begin
                level = 255;
            end
            prod = (level * int'(gain)) >>> AMP_FRAC;
            return (prod > 255) ? 8'hFF : SMP_W'(prod);
        endfunction

        // Per-sub-step change between the point below idx and idx itself,
        // truncated towards zero; zero outside the table.
        function logic signed [SLOPE_W-1:0] slope_after(int unsigned idx);
            int diff;
            if (idx == 0 || idx >= TBL_LEN) begin
                return '0;
            end
            diff = int'(wave[idx]) - int'(wave[idx - 1]);
            return SLOPE_W'(diff / SUBSTEPS);
        endfunction

        // Called for every accepted input word; queues the level it must produce.
        function void note_word(logic op_in, logic [TIME_W-1:0] now,
                                logic [IDX_W-1:0] idx, logic [SMP_W-1:0] value);
            logic [TIME_W-1:0] elapsed;
            logic [TIME_W-1:0] point_bound;
            logic [TIME_W-1:0] sub_bound;
            int                level;
            if (op_in == OP_LOAD) begin
                wave[idx] = value;
                return;
            end
            if (!cycling) begin
                cycling       = 1'b1;
                phase_start   = now;
                step_length   = LEN_W'(duration / (TBL_LEN - 1));
                step_index    = 1;
                substep_count = '0;
                step_slope    = slope_after(1);
                pending_levels.push_back(scaled(int'(wave[0])));
                return;
            end
            elapsed     = now - phase_start;
            point_bound = TIME_W'(step_index) * TIME_W'(step_length);
            sub_bound   = TIME_W'(step_index - 1) * TIME_W'(step_length)
                        + (TIME_W'(substep_count) * TIME_W'(step_length)) / TIME_W'(SUBSTEPS);
            if (step_index >= TBL_LEN || elapsed >= TIME_W'(duration)) begin
                cycling = 1'b0;
                return;
            end
            if (elapsed > point_bound) begin
                pending_levels.push_back(scaled(int'(wave[step_index])));
                step_index    = step_index + 1;
                step_slope    = slope_after(step_index);
                substep_count = 1;
                return;
            end
            if (elapsed > sub_bound) begin
                level = int'(wave[step_index - 1]) + int'(substep_count) * int'(step_slope);
                pending_levels.push_back(scaled(level));
                substep_count = substep_count + 1;
            end
        endfunction

        // Called for every accepted output word.
        task check_level(logic [SMP_W-1:0] got);
            logic [SMP_W-1:0] want;
            if (pending_levels.size() == 0) begin
                report($sformatf("drive_level %0d arrived with nothing expected", got));
                return;
            end
            want = pending_levels.pop_front();
            if (got !== want) begin
                report($sformatf("drive_level %0d, expected %0d", got, want));
            end
        endtask

        task check_drained();
            if (pending_levels.size() != 0) begin
                report($sformatf("%0d expected drive levels never arrived",
                                 pending_levels.size()));
            end
        endtask
    endclass

endpackage

>>> bench/tb_wavetable_interp_player.sv
// Top-level bench for wavetable_interp_player: drives tick and load words and APB
// register writes, and checks every drive_level word against level_scoreboard.
// Depends on wip_pkg and wip_tb_pkg.
module tb_wavetable_interp_player;
    import wip_pkg::*;
    import wip_tb_pkg::*;

    // Length of the deliberate output stall, long enough that the output
    // register and the sequencer behind it both fill and in_ready drops.
    localparam int LONG_HOLD    = 400;
    // A tick that gives no word may still be in the sequencer when the last
    // expected word has arrived.
    localparam int QUIET_CYCLES = 16;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               op          = OP_TICK;
    logic [TIME_W-1:0]  time_ms     = '0;
    logic [IDX_W-1:0]   table_index = '0;
    logic [SMP_W-1:0]   table_value = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [SMP_W-1:0]   drive_level;

    level_scoreboard sb;

    // Per-phase idling: each side draws a random wait, bounded by this value, before each word.
    int unsigned send_gap_max = 0;
    int unsigned recv_gap_max = 0;
    // Raised by the stimulus to ask the output side for one long stall.
    bit          hold_output  = 1'b0;

    wavetable_interp_player u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .time_ms     (time_ms),
        .table_index (table_index),
        .table_value (table_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_level (drive_level)
    );

    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // APB write: setup cycle, then access cycle. pready is tied high, so the
    // register takes the value at the first rising edge of the access phase.
    // The scoreboard copy is updated at the same point.
    task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(sel, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one input word after a random wait and holds it, unchanged,
    // until the block takes it. The word is handed to the scoreboard at the
    // accepting edge, before any level it causes can come out.
    task automatic send_word(input logic op_in, input logic [TIME_W-1:0] t,
                             input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] value);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        op          <= op_in;
        time_ms     <= t;
        table_index <= idx;
        table_value <= value;
        do @(posedge clk); while (!in_ready);
        sb.note_word(op_in, t, idx, value);
    endtask

    // The unused fields of a word carry random values so that every bit of
    // every field toggles across the run.
    task automatic tick_word(input logic [TIME_W-1:0] t);
        send_word(OP_TICK, t, IDX_W'($urandom_range(0, TBL_LEN - 1)),
                  SMP_W'($urandom_range(0, 255)));
    endtask

    task automatic load_word(input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] value);
        send_word(OP_LOAD, $urandom(), idx, value);
    endtask

    // Stop offering words and wait until every expected level has come out.
    task automatic drain_levels();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Drained and quiet: safe to touch the registers or to finish.
    task automatic settle();
        drain_levels();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // One phase of random play. Most words are ticks whose times creep
    // forward by at most half a step plus one, so that cycles run through their
    // points and sub-steps; some are table loads landing mid-cycle, some are
    // jumps that end a cycle on its duration, and a few are arbitrary times.
    // A new cycle starts at a random time, often just below the 32-bit wrap.
    task automatic play_phase(input logic [DUR_W-1:0] dur, input logic [AMP_W-1:0] amp,
                              input int unsigned gap_in, input int unsigned gap_out,
                              input int unsigned n_words, input bit long_hold,
                              input bit mid_pause);
        logic [TIME_W-1:0] tick_time;
        int unsigned       k;
        int unsigned       roll;
        int unsigned       span;
        int unsigned       len;
        settle();
        write_reg(REG_DURATION, PDATA_W'(dur));
        write_reg(REG_AMPLITUDE, PDATA_W'(amp));
        send_gap_max = gap_in;
        recv_gap_max = gap_out;
        span         = int'(dur);
        tick_time    = '0;
        for (k = 0; k < n_words; k++)
        begin
            if (long_hold && k == n_words / 4)
            begin
                hold_output = 1'b1;
            end
            if (mid_pause && k == n_words / 2)
            begin
                drain_levels();
            end
            roll = $urandom_range(0, 99);
            len  = int'(sb.step_length);
            if (roll < 10)
            begin
                load_word(IDX_W'($urandom_range(0, TBL_LEN - 1)),
                          SMP_W'($urandom_range(0, 255)));
            end
            else
            begin
                if (!sb.cycling)
                begin
                    if (roll < 35)
                        tick_time = 32'hFFFF_FFFF - $urandom_range(0, 3 * span + 8);
                    else
                        tick_time = $urandom();
                end
                else if (roll < 14)
                    tick_time = tick_time + $urandom_range(0, span + span / 4 + 2);
                else if (roll < 16)
                    tick_time = $urandom();
                else
                    tick_time = tick_time + $urandom_range(0, len / 2 + 1);
                tick_word(tick_time);
            end
        end
    endtask

    // Output side: waits a random number of cycles per word, or one long
    // stretch when asked, then takes the next word and has it checked.
    initial
    begin : output_side
        int unsigned hold_cycles;
        @(posedge rst_n);
        forever
        begin
            hold_cycles = $urandom_range(0, recv_gap_max);
            if (hold_output)
            begin
                hold_cycles = LONG_HOLD;
                hold_output = 1'b0;
            end
            repeat (hold_cycles)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            sb.check_level(drive_level);
        end
    end

    // Stimulus: reset, a directed run with the reset register values, a short
    // zero-duration check, then several random phases across the register
    // extremes, with the two sides idling in different combinations.
    initial
    begin : stimulus
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: 1000 ms, unity gain, so a step is 32 ms.
        load_word(5'd0, 8'd0);
        load_word(5'd31, 8'd255);
        tick_word(32'hFFFF_FFF0);   // idle, so a cycle starts and entry 0 comes out
        tick_word(32'hFFFF_FFF0);   // no time has passed: nothing
        tick_word(32'hFFFF_FFF9);   // first sub-step boundary
        tick_word(32'h0000_0011);   // elapsed wraps past zero and beats point 1
        load_word(5'd2, 8'd0);      // load lands inside the running cycle
        tick_word(32'h0000_0100);   // point 2 shows the freshly loaded value
        tick_word(32'h0000_03D8);   // exactly the duration: cycle ends silently
        tick_word(32'hFFFF_FFFF);
        tick_word(32'h5555_5555);   // far beyond the duration
        tick_word(32'hAAAA_AAAA);
        load_word(5'd5, 8'hAA);
        load_word(5'd26, 8'h55);
        tick_word(32'hAAAA_AAB3);
        tick_word(32'hAAAA_AACB);
        tick_word(32'hAAAA_AAD3);

        // Zero duration with full gain: start saturates, next tick ends it.
        settle();
        write_reg(REG_DURATION, PDATA_W'(0));
        write_reg(REG_AMPLITUDE, PDATA_W'(255));
        load_word(5'd0, 8'd200);
        tick_word(32'd7);
        tick_word(32'd7);
        tick_word(32'd8);
        tick_word(32'd0);

        play_phase(16'd1000, 8'd128, 7, 7, 220, 1'b0, 1'b0);
        play_phase(16'd40, 8'd200, 0, 0, 220, 1'b0, 1'b0);
        play_phase(16'd0, 8'd255, 7, 0, 150, 1'b0, 1'b0);
        play_phase(16'hFFFF, 8'd1, 0, 7, 260, 1'b1, 1'b0);
        play_phase(16'd124, 8'd0, 7, 7, 200, 1'b0, 1'b1);
        play_phase(16'd31, 8'd129, 3, 5, 200, 1'b0, 1'b0);
        play_phase(DUR_W'($urandom_range(0, 4000)), AMP_W'($urandom()), 7, 7, 250,
                   1'b0, 1'b1);
        play_phase(DUR_W'($urandom()), AMP_W'($urandom()), 7, 7, 250, 1'b1, 1'b0);

        settle();
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
